FILE: rtl/tbd_pkg.sv
// ============================================================================
// tbd_pkg - shared types and constants for the two-button debounce block
// Widths, register indexes, event codes and the per-button event record.
// ============================================================================
package tbd_pkg;

    // fixed field widths
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int TS_W       = 32;
    localparam int KIND_W     = 2;

    // default counter width for the debounce and long-press countdowns
    localparam int COUNT_WIDTH_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE   = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

    // event kinds
    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG    = 2'd2;

    // button ids
    localparam logic BTN_CONFIRM = 1'b0;
    localparam logic BTN_BACK    = 1'b1;

    // event from one button channel for one tick
    typedef struct packed {
        logic              valid;
        logic              id;
        logic [KIND_W-1:0] kind;
    } ev_t;

    // one queued result beat
    typedef struct packed {
        logic              last;
        logic [TS_W-1:0]   ts;
        logic [KIND_W-1:0] kind;
        logic              id;
    } out_entry_t;

endpackage

FILE: rtl/two_button_debounce_long_press_top.sv
// ============================================================================
// two_button_debounce_long_press_top - confirm/back debounce with long press
// Each input beat is one millisecond tick with the raw active-low levels of
// both buttons; output beats are press, release and long-press events.
// ============================================================================
// A tick is taken whenever the four-entry event queue has room for two
// events, and its events are computed and queued in the cycle it is taken.
// The output side sends one event per cycle while m_tready is high, so
// ticks that cause no events flow at one per cycle while the queue has
// room, and a tick that causes events adds one output beat per event: at
// most two per tick when both buttons report. Events of one tick come out
// confirm first, the final one with tlast set. Configuration writes take
// effect at once and should be issued only while no events are pending.
module two_button_debounce_long_press_top #(
    parameter int COUNT_WIDTH = tbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input tick stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] confirm_level, [1] back_level
    // event stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // [0] button_id, [2:1] event_kind,
                                                      // [34:3] tick_stamp
    output logic                           m_tlast,   // last_of_tick
    // configuration writes
    input  logic                           cfg_we,
    input  logic [tbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tbd_pkg::CFG_W-1:0]      cfg_wdata
);
    import tbd_pkg::*;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int EXT_W   = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [EXT_W-1:0] CNT_MAX = EXT_W'({COUNT_WIDTH{1'b1}});

    // configuration registers
    logic [CFG_W-1:0] debounce_ticks_reg;
    logic [CFG_W-1:0] long_ticks_reg;
    logic             events_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RST;
            long_ticks_reg     <= LONG_RST;
            events_en_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEBOUNCE: debounce_ticks_reg <= cfg_wdata;
                CFG_LONG:     long_ticks_reg     <= cfg_wdata;
                CFG_ENABLE:   events_en_reg      <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // reload values: saturate to the counter width, zero acts as one
    logic [EXT_W-1:0]       deb_ext, long_ext;
    logic [COUNT_WIDTH-1:0] deb_sat, long_sat;
    logic [COUNT_WIDTH-1:0] debounce_reload, long_reload;

    always_comb
    begin
        deb_ext  = EXT_W'(debounce_ticks_reg);
        long_ext = EXT_W'(long_ticks_reg);
        deb_sat  = (deb_ext > CNT_MAX)  ? COUNT_WIDTH'(CNT_MAX) : COUNT_WIDTH'(deb_ext);
        long_sat = (long_ext > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX) : COUNT_WIDTH'(long_ext);
        debounce_reload = (deb_sat == '0)  ? COUNT_WIDTH'(1) : deb_sat;
        long_reload     = (long_sat == '0) ? COUNT_WIDTH'(1) : long_sat;
    end

    // event queue pointers (one extra bit tells full from empty)
    logic [Q_AW:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW:0] rd_ptr_reg;
    logic [Q_AW:0] q_count;
    logic          step;
    logic          pop;

    assign q_count  = wr_ptr_reg - rd_ptr_reg;
    assign s_tready = (q_count <= (Q_AW+1)'(Q_DEPTH - 2));
    assign step     = s_tvalid && s_tready;
    assign m_tvalid = (q_count != '0);
    assign pop      = m_tvalid && m_tready;

    // button channels
    ev_t ev_confirm, ev_back;

    tbd_button #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .BTN_ID      (BTN_CONFIRM)
    ) u_confirm (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .raw             (s_tdata[0]),
        .debounce_reload (debounce_reload),
        .long_reload     (long_reload),
        .events_enabled  (events_en_reg),
        .ev              (ev_confirm)
    );

    tbd_button #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .BTN_ID      (BTN_BACK)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .raw             (s_tdata[1]),
        .debounce_reload (debounce_reload),
        .long_reload     (long_reload),
        .events_enabled  (events_en_reg),
        .ev              (ev_back)
    );

    // millisecond counter, stamped on the events of the current tick
    logic [TS_W-1:0] ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ms_reg <= '0;
        else if (step)
            ms_reg <= ms_reg + TS_W'(1);
    end

    // order the tick's events: confirm first, last flag on the final one
    out_entry_t first_entry, second_entry;
    logic       push_first, push_second;
    logic [Q_AW-1:0] wr_idx0, wr_idx1;

    always_comb
    begin
        push_first  = step && (ev_confirm.valid || ev_back.valid);
        push_second = step && ev_confirm.valid && ev_back.valid;

        first_entry.id   = ev_confirm.valid ? ev_confirm.id   : ev_back.id;
        first_entry.kind = ev_confirm.valid ? ev_confirm.kind : ev_back.kind;
        first_entry.ts   = ms_reg;
        first_entry.last = !(ev_confirm.valid && ev_back.valid);

        second_entry.id   = ev_back.id;
        second_entry.kind = ev_back.kind;
        second_entry.ts   = ms_reg;
        second_entry.last = 1'b1;

        wr_ptr_next = wr_ptr_reg + (Q_AW+1)'(push_first) + (Q_AW+1)'(push_second);
        wr_idx0     = wr_ptr_reg[Q_AW-1:0];
        wr_idx1     = wr_idx0 + Q_AW'(1);
    end

    // queue storage
    out_entry_t q_mem [Q_DEPTH];

    always_ff @(posedge clk)
    begin
        if (push_first)
            q_mem[wr_idx0] <= first_entry;
        if (push_second)
            q_mem[wr_idx1] <= second_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + (Q_AW+1)'(1);
        end
    end

    // output beat from the queue head
    out_entry_t head;

    assign head    = q_mem[rd_ptr_reg[Q_AW-1:0]];
    assign m_tdata = {5'd0, head.ts, head.kind, head.id};
    assign m_tlast = head.last;

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("event queue overrun");

    a_ms_advance: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> ms_reg == $past(ms_reg) + TS_W'(1))
        else $error("millisecond count did not advance on tick");

    a_long_is_back: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:1] == EV_LONG) |-> m_tdata[0] == BTN_BACK)
        else $error("long press reported on confirm");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:1] == EV_PRESS || m_tdata[2:1] == EV_RELEASE
                      || m_tdata[2:1] == EV_LONG))
        else $error("illegal event kind on output");

endmodule

FILE: rtl/tbd_button.sv
// ============================================================================
// tbd_button - one button channel
// Debounce countdown, pressed flag and long-press countdown for one button,
// advanced once per accepted tick; reports at most one event per tick.
// ============================================================================
module tbd_button #(
    parameter int   COUNT_WIDTH = tbd_pkg::COUNT_WIDTH_DEF,
    parameter logic BTN_ID      = tbd_pkg::BTN_CONFIRM
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   raw,
    input  logic [COUNT_WIDTH-1:0] debounce_reload,
    input  logic [COUNT_WIDTH-1:0] long_reload,
    input  logic                   events_enabled,
    output tbd_pkg::ev_t           ev
);
    import tbd_pkg::*;

    logic                   prev_raw_reg,  prev_raw_next;
    logic                   pressed_reg,   pressed_next;
    logic [COUNT_WIDTH-1:0] dcnt_reg,      dcnt_next;
    logic                   drun_reg,      drun_next;
    logic [COUNT_WIDTH-1:0] lcnt_reg,      lcnt_next;
    logic                   lrun_reg,      lrun_next;

    logic now_pressed;
    logic emitted;

    assign now_pressed = ~raw;

    // tick update: debounce first, then long press unless an edge event fired
    always_comb
    begin
        prev_raw_next = prev_raw_reg;
        pressed_next  = pressed_reg;
        dcnt_next     = dcnt_reg;
        drun_next     = drun_reg;
        lcnt_next     = lcnt_reg;
        lrun_next     = lrun_reg;
        emitted       = 1'b0;
        ev            = '0;

        if (raw != prev_raw_reg)
        begin
            // any raw edge restarts the quiet period
            prev_raw_next = raw;
            dcnt_next     = debounce_reload;
            drun_next     = 1'b1;
        end
        else if (drun_reg)
        begin
            if (dcnt_reg <= COUNT_WIDTH'(1))
            begin
                dcnt_next = '0;
                drun_next = 1'b0;
                if (now_pressed != pressed_reg)
                begin
                    pressed_next = now_pressed;
                    if (events_enabled)
                    begin
                        emitted  = 1'b1;
                        ev.valid = 1'b1;
                        ev.id    = BTN_ID;
                        ev.kind  = now_pressed ? EV_PRESS : EV_RELEASE;
                        // press arms the long-press timer, release cancels it
                        lcnt_next = now_pressed ? long_reload : '0;
                        lrun_next = now_pressed;
                    end
                end
            end
            else
            begin
                dcnt_next = dcnt_reg - COUNT_WIDTH'(1);
            end
        end

        // long-press countdown
        if (!emitted && lrun_reg)
        begin
            if (lcnt_reg <= COUNT_WIDTH'(1))
            begin
                lcnt_next = '0;
                lrun_next = 1'b0;
                if (pressed_next && events_enabled)
                begin
                    // long press is always reported as back
                    ev.valid = 1'b1;
                    ev.id    = BTN_BACK;
                    ev.kind  = EV_LONG;
                end
            end
            else
            begin
                lcnt_next = lcnt_reg - COUNT_WIDTH'(1);
            end
        end
    end

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b1;
            pressed_reg  <= 1'b0;
            dcnt_reg     <= '0;
            drun_reg     <= 1'b0;
            lcnt_reg     <= '0;
            lrun_reg     <= 1'b0;
        end
        else if (step)
        begin
            prev_raw_reg <= prev_raw_next;
            pressed_reg  <= pressed_next;
            dcnt_reg     <= dcnt_next;
            drun_reg     <= drun_next;
            lcnt_reg     <= lcnt_next;
            lrun_reg     <= lrun_next;
        end
    end

endmodule

FILE: dv/tb_two_button_debounce_long_press_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_two_button_debounce_long_press_top - event check for the button debouncer
// Streams millisecond ticks into the block, mirrors the debounce and
// long-press behavior in a local predictor and checks every event beat in
// order, over several register settings and idle patterns on both sides.
// ============================================================================
module tb_two_button_debounce_long_press_top;

    import tbd_pkg::*;

    localparam int CW = COUNT_WIDTH_DEF;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << CW) - 64'd1);
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 12;
    localparam int MAX_PRINTS = 40;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'd0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_DEBOUNCE;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    two_button_debounce_long_press_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ticks waiting to be sent and events waiting to arrive
    logic [7:0]  tick_q[$];
    out_entry_t  event_q[$];
    idle_mode_t  idle_mode = IDLE_NONE;
    int          err_count = 0;
    int          quiet_cycles = 0;

    // mirrored registers
    logic [15:0] mir_debounce = DEBOUNCE_RST;
    logic [15:0] mir_long = LONG_RST;
    logic        mir_enable = 1'b1;

    // mirrored per-button state
    logic        prev_raw[2] = '{1'b1, 1'b1};
    logic        pressed[2] = '{1'b0, 1'b0};
    logic [31:0] deb_cnt[2] = '{32'd0, 32'd0};
    logic        deb_run[2] = '{1'b0, 1'b0};
    logic [31:0] long_cnt[2] = '{32'd0, 32'd0};
    logic        long_run[2] = '{1'b0, 1'b0};
    logic [31:0] ms_count = 32'd0;

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // countdown reload: zero acts as one, large values clip to counter max
    function automatic logic [31:0] reload_count(input logic [15:0] v);
        logic [31:0] r;
        r = {16'd0, v};
        if (r > CNT_MAX)
            r = CNT_MAX;
        if (r == 32'd0)
            r = 32'd1;
        return r;
    endfunction

    // one tick of a countdown, 1 on expiry
    function automatic bit count_tick(input bit is_long, input int b);
        logic [31:0] c;
        logic        r;
        c = is_long ? long_cnt[b] : deb_cnt[b];
        r = is_long ? long_run[b] : deb_run[b];
        if (!r)
            return 1'b0;
        if (c <= 32'd1)
        begin
            if (is_long)
            begin
                long_cnt[b] = 32'd0;
                long_run[b] = 1'b0;
            end
            else
            begin
                deb_cnt[b] = 32'd0;
                deb_run[b] = 1'b0;
            end
            return 1'b1;
        end
        if (is_long)
            long_cnt[b] = c - 32'd1;
        else
            deb_cnt[b] = c - 32'd1;
        return 1'b0;
    endfunction

    // events caused by one tick, confirm first, last one flagged
    task automatic predict_tick_events(input logic [1:0] lvl);
        out_entry_t tick_ev[2];
        int         n;
        bit         emitted;
        logic       now_pressed;
        n = 0;
        for (int b = 0; b < 2; b++)
        begin
            emitted = 1'b0;
            if (lvl[b] != prev_raw[b])
            begin
                prev_raw[b] = lvl[b];
                deb_cnt[b]  = reload_count(mir_debounce);
                deb_run[b]  = 1'b1;
            end
            else if (count_tick(1'b0, b))
            begin
                now_pressed = ~lvl[b];
                if (now_pressed != pressed[b])
                begin
                    pressed[b] = now_pressed;
                    if (mir_enable)
                    begin
                        tick_ev[n].id   = (b == 1) ? BTN_BACK : BTN_CONFIRM;
                        tick_ev[n].kind = now_pressed ? EV_PRESS : EV_RELEASE;
                        tick_ev[n].ts   = ms_count;
                        tick_ev[n].last = 1'b0;
                        n++;
                        emitted = 1'b1;
                        long_cnt[b] = now_pressed ? reload_count(mir_long) : 32'd0;
                        long_run[b] = now_pressed;
                    end
                end
            end
            if (!emitted && count_tick(1'b1, b))
            begin
                // long press always reports as back
                if (pressed[b] && mir_enable)
                begin
                    tick_ev[n].id   = BTN_BACK;
                    tick_ev[n].kind = EV_LONG;
                    tick_ev[n].ts   = ms_count;
                    tick_ev[n].last = 1'b0;
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            tick_ev[i].last = (i == n - 1);
            event_q.push_back(tick_ev[i]);
        end
        ms_count = ms_count + 32'd1;
    endtask

    // tick driver
    always @(posedge clk)
    begin : drv
        bit gap;
        gap = ((idle_mode == IDLE_SEND) && ($urandom_range(99) < 71)) ||
              ((idle_mode == IDLE_BOTH) && ($urandom_range(99) < 8));
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (tick_q.size() > 0 && !gap)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= tick_q.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // event receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (idle_mode == IDLE_RECV)
            m_tready <= ($urandom_range(99) >= 71);
        else if (idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(99) >= 8);
        else
            m_tready <= 1'b1;
    end

    // monitor: register mirror, tick prediction, event check, watchdog
    always @(posedge clk)
    begin : mon
        out_entry_t exp_ev;
        out_entry_t got_ev;
        bit         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_DEBOUNCE)
                    mir_debounce = cfg_wdata;
                else if (cfg_addr == CFG_LONG)
                    mir_long = cfg_wdata;
                else if (cfg_addr == CFG_ENABLE)
                    mir_enable = cfg_wdata[0];
            end
            if (s_tvalid && s_tready)
            begin
                predict_tick_events(s_tdata[1:0]);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                got_ev.id   = m_tdata[0];
                got_ev.kind = m_tdata[2:1];
                got_ev.ts   = m_tdata[34:3];
                got_ev.last = m_tlast;
                if (event_q.size() == 0)
                begin
                    report_error($sformatf("unexpected beat id %0d kind %0d ts %0d",
                                           got_ev.id, got_ev.kind, got_ev.ts));
                end
                else
                begin
                    exp_ev = event_q.pop_front();
                    if (got_ev.id !== exp_ev.id)
                        report_error($sformatf("ts %0d button_id %0d, want %0d",
                                               exp_ev.ts, got_ev.id, exp_ev.id));
                    if (got_ev.kind !== exp_ev.kind)
                        report_error($sformatf("ts %0d event_kind %0d, want %0d",
                                               exp_ev.ts, got_ev.kind, exp_ev.kind));
                    if (got_ev.ts !== exp_ev.ts)
                        report_error($sformatf("tick_stamp %0d, want %0d",
                                               got_ev.ts, exp_ev.ts));
                    if (got_ev.last !== exp_ev.last)
                        report_error($sformatf("ts %0d tlast %0d, want %0d",
                                               exp_ev.ts, got_ev.last, exp_ev.last));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_two_button_debounce_long_press_top: errors");
                $finish;
            end
        end
    end

    // wait until every tick is sent and every event has arrived
    task automatic wait_drained();
        while (tick_q.size() > 0 || s_tvalid || event_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] deb, input logic [15:0] lng,
                              input logic en);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge clk);
        cfg_addr  <= CFG_LONG;
        cfg_wdata <= lng;
        @(posedge clk);
        cfg_addr  <= CFG_ENABLE;
        cfg_wdata <= {15'd0, en};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic push_ticks(input logic [1:0] lvl, input int count);
        for (int i = 0; i < count; i++)
            tick_q.push_back({6'd0, lvl});
    endtask

    // random level runs: mostly held long enough to settle, some glitches
    task automatic push_random_runs(input int count, input logic [15:0] deb,
                                    input logic [15:0] lng);
        int          left;
        int          hold;
        int          span;
        logic [1:0]  lvl;
        left = count;
        lvl  = 2'b11;
        span = ((reload_count(deb) > 12) ? 12 : int'(reload_count(deb))) +
               ((reload_count(lng) > 12) ? 12 : int'(reload_count(lng))) + 3;
        while (left > 0)
        begin
            lvl = lvl ^ 2'($urandom_range(1, 3));
            if ($urandom_range(99) < 20)
                hold = $urandom_range(1, 2);
            else
                hold = $urandom_range(1, span);
            if (hold > left)
                hold = left;
            push_ticks(lvl, hold);
            left -= hold;
        end
    endtask

    initial
    begin : stim
        logic [15:0] ph_deb[10];
        logic [15:0] ph_long[10];
        logic        ph_en[10];
        int          ph_items[10];
        ph_deb   = '{16'd1, 16'd2, 16'd3, 16'd0, 16'd1, 16'd4, 16'd2, 16'd1,
                     16'd65535, 16'd1};
        ph_long  = '{16'd1, 16'd3, 16'd6, 16'd0, 16'd8, 16'd2, 16'd5, 16'd3,
                     16'd65535, 16'd2};
        ph_en    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        ph_items = '{130, 130, 130, 130, 130, 130, 130, 130, 40, 130};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: both held down until the default debounce expires
        push_ticks(2'b00, 21);
        wait_drained();

        // shortest timers: same-tick releases, press then long press as back
        write_regs(16'd1, 16'd2, 1'b1);
        push_ticks(2'b11, 2);
        push_ticks(2'b10, 4);
        push_ticks(2'b00, 3);
        wait_drained();

        // release while events are off, then long timer expires released
        write_regs(16'd1, 16'd5, 1'b1);
        push_ticks(2'b11, 2);
        push_ticks(2'b10, 2);
        wait_drained();
        write_regs(16'd1, 16'd5, 1'b0);
        push_ticks(2'b11, 2);
        wait_drained();
        write_regs(16'd1, 16'd5, 1'b1);
        push_ticks(2'b11, 4);
        wait_drained();

        // random phases cycling through the idle patterns
        for (int p = 0; p < 10; p++)
        begin
            write_regs(ph_deb[p], ph_long[p], ph_en[p]);
            idle_mode <= idle_mode_t'(p % 4);
            push_random_runs(ph_items[p], ph_deb[p], ph_long[p]);
            wait_drained();
        end

        idle_mode <= IDLE_NONE;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && event_q.size() == 0)
            $display("tb_two_button_debounce_long_press_top: clean");
        else
            $display("tb_two_button_debounce_long_press_top: errors");
        $finish;
    end

endmodule
